FILE: sv/cap_pkg.sv
// shared types, register codes and arithmetic helpers for coverage-to-pixel conversion
package cap_pkg;

  localparam int ACC_W   = 16;
  localparam int GRAY_W  = 8;
  localparam int POS_W   = 10;
  localparam int DIM_W   = 11;
  localparam int PIXEL_W = 3 * GRAY_W;

  localparam logic [DIM_W-1:0]  DIM_RESET = 11'd1024;
  localparam logic [GRAY_W-1:0] GRAY_MAX  = 8'hFF;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // one raster cell
  typedef struct packed {
    logic signed [ACC_W-1:0] edge_delta;
    logic signed [ACC_W-1:0] tail_delta;
  } in_word_t;

  // one gray pixel with its position
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_word;
    logic [POS_W-1:0]   pixel_row;
    logic [POS_W-1:0]   pixel_column;
    logic               image_done;
  } out_word_t;

  // 16-bit add that saturates at both ends
  function automatic logic signed [ACC_W-1:0] sat_add16(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  // clamp a signed coverage value to 0..255
  function automatic logic [GRAY_W-1:0] to_gray(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1]) begin
      return '0;
    end
    if (v > $signed({{(ACC_W-GRAY_W){1'b0}}, GRAY_MAX})) begin
      return GRAY_MAX;
    end
    return v[GRAY_W-1:0];
  endfunction

endpackage

FILE: sv/cap_ram.sv
// generic single-write, single-read ram with registered read data
module cap_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while disabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/coverage_accumulate_to_pixels_top.sv
// coverage accumulation top: column accumulator memory, cell pipeline and pixel output register
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+----------------------------------
//   in_     | input     | in_valid/in_stall  | edge_delta, tail_delta
//   out_    | output    | out_valid/out_stall| pixel_word, row, column, done
//   cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// one cell per cycle sustained while in_stall is low; a cell is taken into the middle stage
//   and its pixel is registered in the output register when the cell leaves the middle stage
// the accumulator memory is read in the cycle a cell is taken and written back when
//   the cell leaves the middle stage, which a held output can delay;
//   a column comes round again only after at least eight cells
// reset (synchronous) clears counters and valids and sets the width/height registers to 1024;
//   the accumulator memory is not cleared, row 0 of every image reads as zero
// out_stall holds the output register; the middle stage keeps accepting cells that
//   give no pixel, so in_stall rises only when both later stages are full
module coverage_accumulate_to_pixels_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cap_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output cap_pkg::out_word_t                out_data,
  input  logic                              cfg_we,
  input  cap_pkg::cfg_reg_t                 cfg_index,
  input  logic [cap_pkg::DIM_W-1:0]         cfg_data
);

  import cap_pkg::*;

  localparam int DEPTH = ((MAX_WIDTH + 7) / 8) * 8;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = (CW > DIM_W) ? CW : DIM_W;
  localparam int YW    = (RW > DIM_W) ? RW : DIM_W;
  localparam int CXW   = (CW > POS_W) ? CW : POS_W;
  localparam int RXW   = (RW > POS_W) ? RW : POS_W;
  localparam logic [XW-1:0] MAXW_X = XW'(MAX_WIDTH);
  localparam logic [YW-1:0] MAXH_Y = YW'(MAX_HEIGHT);

  // configuration registers
  logic [DIM_W-1:0] width_cfg_r;
  logic [DIM_W-1:0] height_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= DIM_RESET;
      height_cfg_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_cfg_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: height_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective width, padded width and height
  logic [XW-1:0] width_x;
  logic [YW-1:0] height_y;
  logic [CW-1:0] width_eff;
  logic [RW-1:0] height_eff;
  logic [CW-1:0] width_p7;
  logic [CW-1:0] pad_width;

  always_comb begin
    width_x  = XW'(width_cfg_r);
    height_y = YW'(height_cfg_r);
    if (width_x == '0) begin
      width_eff = CW'(1);
    end else if (width_x > MAXW_X) begin
      width_eff = MAXW_X[CW-1:0];
    end else begin
      width_eff = width_x[CW-1:0];
    end
    if (height_y == '0) begin
      height_eff = RW'(1);
    end else if (height_y > MAXH_Y) begin
      height_eff = MAXH_Y[RW-1:0];
    end else begin
      height_eff = height_y[RW-1:0];
    end
    width_p7  = width_eff + CW'(7);
    pad_width = {width_p7[CW-1:3], 3'b000};
  end

  // raster position counters
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_inc, row_cur;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic          cell_produce;
  logic          cell_done;
  logic          in_accept;

  always_comb begin
    // a counter left past the row end by a narrower width starts the next row
    if (col_r >= pad_width) begin
      col_cur = '0;
      row_inc = row_r + RW'(1);
    end else begin
      col_cur = col_r;
      row_inc = row_r;
    end
    row_cur  = (row_inc >= height_eff) ? '0 : row_inc;
    col_next = col_cur + CW'(1);
    row_next = row_cur + RW'(1);
    cell_produce = col_cur < width_eff;
    cell_done    = (row_cur == height_eff - RW'(1)) && (col_cur == width_eff - CW'(1));
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_accept) begin
      if (col_next >= pad_width) begin
        col_nxt = '0;
        row_nxt = (row_next >= height_eff) ? '0 : row_next;
      end else begin
        col_nxt = col_next;
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // middle stage: cell waits here for its accumulator read
  logic                    s1_valid_r;
  logic [AW-1:0]           s1_addr_r;
  logic [POS_W-1:0]        s1_row_r;
  logic [POS_W-1:0]        s1_col_r;
  logic                    s1_first_r;
  logic                    s1_produce_r;
  logic                    s1_done_r;
  logic signed [ACC_W-1:0] s1_edge_r;
  logic signed [ACC_W-1:0] s1_tail_r;
  logic                    s1_advance;
  logic [RXW-1:0]          row_wide;
  logic [CXW-1:0]          col_wide;

  logic out_valid_r;
  out_word_t out_data_r;

  // handshake: middle stage frees when it drains or its cell gives no pixel
  assign s1_advance = s1_valid_r && (!s1_produce_r || !out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_accept  = in_valid && !in_stall;
  assign row_wide   = RXW'(row_cur);
  assign col_wide   = CXW'(col_cur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr_r    <= col_cur[AW-1:0];
      s1_row_r     <= row_wide[POS_W-1:0];
      s1_col_r     <= col_wide[POS_W-1:0];
      s1_first_r   <= (row_cur == '0);
      s1_produce_r <= cell_produce;
      s1_done_r    <= cell_done;
      s1_edge_r    <= in_data.edge_delta;
      s1_tail_r    <= in_data.tail_delta;
    end
  end

  // column accumulator memory
  logic [ACC_W-1:0]        acc_rd;
  logic signed [ACC_W-1:0] acc_cur;
  logic signed [ACC_W-1:0] acc_new;
  logic signed [ACC_W-1:0] cell_sum;
  logic [GRAY_W-1:0]       gray;

  cap_ram #(
    .WIDTH (ACC_W),
    .DEPTH (DEPTH)
  ) u_acc_ram (
    .clk     (clk),
    .wr_en   (s1_advance),
    .wr_addr (s1_addr_r),
    .wr_data (acc_new),
    .rd_en   (in_accept),
    .rd_addr (col_cur[AW-1:0]),
    .rd_data (acc_rd)
  );

  // accumulate: row 0 starts from zero
  always_comb begin
    acc_cur  = s1_first_r ? '0 : $signed(acc_rd);
    cell_sum = sat_add16(acc_cur, s1_edge_r);
    acc_new  = sat_add16(acc_cur, s1_tail_r);
    gray     = to_gray(cell_sum);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && s1_produce_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_produce_r) begin
      out_data_r.pixel_word   <= {gray, gray, gray};
      out_data_r.pixel_row    <= s1_row_r;
      out_data_r.pixel_column <= s1_col_r;
      out_data_r.image_done   <= s1_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // last visible column of the current geometry
  function automatic logic [POS_W-1:0] s1_done_col();
    logic [CXW-1:0] last;
    last = CXW'(width_eff - CW'(1));
    return last[POS_W-1:0];
  endfunction

  // a column is never read and written back in the same cycle
  a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && s1_advance) |-> (col_cur[AW-1:0] != s1_addr_r))
    else $error("accumulator read and write collide");

  // a pixel appears only from a middle-stage cell that drained
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_advance && s1_produce_r))
    else $error("pixel without a drained cell");

  // a held middle stage keeps its cell
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_advance) |=> (s1_valid_r && $stable(s1_addr_r)))
    else $error("middle stage lost its cell");

  // the last pixel sits in the last visible column
  a_done_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.image_done) |-> (out_data_r.pixel_column == s1_done_col()))
    else $error("image end flagged off the last column");

  // padding cells never reach the output
  a_pad_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && !s1_produce_r && !out_stall) |=> !out_valid_r)
    else $error("padding cell produced a pixel");

endmodule

FILE: tb/sv/coverage_pixel_checker.sv
// checker: follows the cell and pixel channels, predicts each gray pixel and compares it
`timescale 1ns / 100ps
module coverage_pixel_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  cap_pkg::in_word_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  cap_pkg::out_word_t            out_data,
  input  logic                          cfg_we,
  input  cap_pkg::cfg_reg_t             cfg_index,
  input  logic [cap_pkg::DIM_W-1:0]     cfg_data,
  output int                            mismatch_count,
  output int                            pixels_due
);
  import cap_pkg::*;

  localparam int PRINT_CAP = 100;

  // predicted block state
  shortint          column_acc [MAX_WIDTH];
  int unsigned      column_pos;
  int unsigned      row_pos;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  out_word_t        pixels_expected [$];
  int               mismatches;

  // zero counts as one, anything past the maximum as the maximum
  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw, input int unsigned limit);
    if (raw == '0) return 1;
    return (raw > limit) ? limit : raw;
  endfunction

  // signed 16-bit sum pinned at both rails
  function automatic shortint add_sat(input int a, input int b);
    int s;
    s = a + b;
    if (s > 32767) return 32767;
    if (s < -32768) return -32768;
    return shortint'(s);
  endfunction

  // step the raster position by one word and queue the pixel it gives, if any
  function automatic void shade_cell(input in_word_t raster_word);
    int unsigned      w;
    int unsigned      h;
    int unsigned      padded;
    int               acc;
    shortint          value;
    logic [GRAY_W-1:0] gray;
    out_word_t        px;
    w      = clamp_dim(width_reg, MAX_WIDTH);
    h      = clamp_dim(height_reg, MAX_HEIGHT);
    padded = (w + 7) & ~32'd7;
    // geometry may have shrunk under the counters
    if (column_pos >= padded) begin
      column_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    acc   = (row_pos == 0) ? 0 : int'(column_acc[column_pos]);
    value = add_sat(acc, int'(shortint'(raster_word.edge_delta)));
    column_acc[column_pos] = add_sat(acc, int'(shortint'(raster_word.tail_delta)));
    if (value < 0) gray = '0;
    else if (value > 255) gray = GRAY_MAX;
    else gray = GRAY_W'(value);
    // padding columns update the accumulator but give no pixel
    if (column_pos < w) begin
      px.pixel_word   = {3{gray}};
      px.pixel_row    = POS_W'(row_pos);
      px.pixel_column = POS_W'(column_pos);
      px.image_done   = (row_pos == h - 1) && (column_pos == w - 1);
      pixels_expected.push_back(px);
    end
    column_pos++;
    if (column_pos >= padded) begin
      column_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t: pixel mismatch: %s", $time, what);
  endtask

  // sample both channels and the register port on every rising edge
  always @(posedge clk) begin : watch_channels
    out_word_t want;
    if (!rst_n) begin
      column_pos = 0;
      row_pos    = 0;
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      mismatches = 0;
      pixels_expected.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pixels_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected word row %0d column %0d",
                                    out_data.pixel_row, out_data.pixel_column));
        end else begin
          want = pixels_expected.pop_front();
          if (out_data.pixel_word !== want.pixel_word)
            report_mismatch($sformatf("pixel_word 0x%0h, want 0x%0h (row %0d column %0d)",
                                      out_data.pixel_word, want.pixel_word,
                                      want.pixel_row, want.pixel_column));
          if (out_data.pixel_row !== want.pixel_row)
            report_mismatch($sformatf("pixel_row %0d, want %0d",
                                      out_data.pixel_row, want.pixel_row));
          if (out_data.pixel_column !== want.pixel_column)
            report_mismatch($sformatf("pixel_column %0d, want %0d",
                                      out_data.pixel_column, want.pixel_column));
          if (out_data.image_done !== want.image_done)
            report_mismatch($sformatf("image_done %0b, want %0b (row %0d column %0d)",
                                      out_data.image_done, want.image_done,
                                      want.pixel_row, want.pixel_column));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: width_reg = cfg_data;
          CFG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) shade_cell(in_data);
    end
    mismatch_count <= mismatches;
    pixels_due     <= pixels_expected.size();
  end

endmodule

FILE: tb/sv/coverage_accumulate_to_pixels_top_test.sv
// testbench top: drives raster words, geometry and back-pressure into the block and gives the verdict
`timescale 1ns / 100ps
module coverage_accumulate_to_pixels_top_test;
  import cap_pkg::*;

  localparam int          MAX_W           = 1024;
  localparam int          MAX_H           = 1024;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          PHASE_CELLS     = 60;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_word_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_data;
  logic             cfg_we    = 1'b0;
  cfg_reg_t         cfg_index = CFG_IMAGE_WIDTH;
  logic [DIM_W-1:0] cfg_data  = '0;

  int               send_gap_pct = 20;
  int               stall_pct    = 61;
  int               phase_idx    = 0;
  bit               held_off     = 1'b0;
  int               mismatch_count;
  int               pixels_due;
  int unsigned      cycles       = 0;

  coverage_accumulate_to_pixels_top #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  coverage_pixel_checker #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) pixel_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_count(mismatch_count),
    .pixels_due(pixels_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // pixel receiver: random stalls, plus one long hold-off in the last phase
  initial begin
    forever begin
      @(posedge clk);
      if (phase_idx == 2 && !held_off) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic logic [ACC_W-1:0] corner_value(input int unsigned i);
    case (i)
      0: return 16'h8000;
      1: return 16'hFFFF;
      2: return 16'h0000;
      3: return 16'h0001;
      4: return 16'h00FF;
      5: return 16'h0100;
      6: return 16'h7FFF;
      default: return 16'h0080;
    endcase
  endfunction

  // mix of full-range, near-zero, gray-range and rail values
  function automatic logic [ACC_W-1:0] random_delta();
    case ($urandom_range(0, 3))
      0: return ACC_W'($urandom());
      1: return ACC_W'(int'($urandom_range(0, 600)) - 300);
      2: return corner_value($urandom_range(0, 7));
      default: return ACC_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_word_t make_cell(input logic [ACC_W-1:0] e, input logic [ACC_W-1:0] t);
    in_word_t w;
    w.edge_delta = e;
    w.tail_delta = t;
    return w;
  endfunction

  // offer one word, with random gaps ahead of it, and hold it until taken
  task automatic send_cell(input in_word_t w);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait until every predicted pixel is out, then let the pipe settle with no words offered
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pixels_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= w_raw;
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= h_raw;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // whole images of random geometry until the phase has enough words
  task automatic run_random_phase();
    int               sent;
    int               n_cells;
    logic [DIM_W-1:0] w_raw;
    logic [DIM_W-1:0] h_raw;
    int unsigned      w_eff;
    int unsigned      h_eff;
    sent = 0;
    while (sent < PHASE_CELLS) begin
      case ($urandom_range(0, 9))
        0: begin
          w_raw = DIM_W'($urandom_range(25, 64));
          h_raw = DIM_W'($urandom_range(0, 1));
        end
        1: begin
          w_raw = '0;
          h_raw = DIM_W'($urandom_range(0, 6));
        end
        default: begin
          w_raw = DIM_W'($urandom_range(1, 24));
          h_raw = DIM_W'($urandom_range(1, 4));
        end
      endcase
      w_eff = (w_raw == 0) ? 1 : (w_raw > MAX_W) ? MAX_W : w_raw;
      h_eff = (h_raw == 0) ? 1 : (h_raw > MAX_H) ? MAX_H : h_raw;
      n_cells = $urandom_range(1, 2) * ((w_eff + 7) / 8) * 8 * h_eff;
      set_geometry(w_raw, h_raw);
      repeat (n_cells) begin
        send_cell(make_cell(random_delta(), random_delta()));
        sent++;
      end
      drain();
    end
  endtask

  initial begin : stimulus
    int r;
    int c;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // small full image walking the rail values through edge and tail
    set_geometry(8, 3);
    for (r = 0; r < 3; r++)
      for (c = 0; c < 8; c++)
        send_cell(make_cell(corner_value((c + r) % 8), corner_value((c + 2 * r + 6) % 8)));
    drain();

    // zero registers act as one: a single visible pixel and seven padding words
    set_geometry(0, 0);
    for (c = 0; c < 8; c++) send_cell(make_cell(corner_value(c), corner_value(7 - c)));
    drain();

    // oversized width clamps to the widest row, a short run along its start
    set_geometry(2047, 1);
    repeat (16) send_cell(make_cell(random_delta(), random_delta()));
    drain();

    // tallest image: narrower width wraps to the next row, full positive tail
    // saturates down the column
    set_geometry(1, 2047);
    for (c = 0; c < 24; c++) send_cell(make_cell(corner_value((c / 8) % 8 + 2), 16'h7FFF));
    drain();

    // height cut below the current row restarts the image at row 0
    set_geometry(9, 3);
    repeat (26) send_cell(make_cell(random_delta(), random_delta()));
    drain();

    // narrowing past the current column wraps to the next row, short height wraps to row 0
    set_geometry(3, 2);
    repeat (16) send_cell(make_cell(random_delta(), random_delta()));
    drain();

    // random images under three idling patterns
    run_random_phase();
    send_gap_pct = 61;
    stall_pct    = 20;
    phase_idx    = 1;
    run_random_phase();
    send_gap_pct = 0;
    stall_pct    = 0;
    phase_idx    = 2;
    run_random_phase();

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
